FILE: rtl/lzd_pkg.sv
package lzd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WinAw    = 12;
  localparam int unsigned WinDepth = 1 << WinAw;
  localparam int unsigned FillW    = WinAw + 1;
  localparam int unsigned RemW     = 5;
  localparam int unsigned LenBias  = 2;

  localparam logic [WinAw-1:0] WinStart  = 12'hFEE;
  localparam logic [FillW-1:0] WinFull   = FillW'(WinDepth);
  localparam logic [3:0]       FlagCount = 4'd8;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             stream_end;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
  } out_req_t;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_HIGH  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    TK_NONE = 2'd0,
    TK_LIT  = 2'd1,
    TK_COPY = 2'd2
  } tok_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic accept;
    logic issue_read;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    tok_kind_e kind;
    logic      final_byte;
    logic      out_full;
  } dp_status_t;

endpackage

FILE: rtl/lzd_ctrl.sv
module lzd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lzd_pkg::dp_status_t status_i,
  output lzd_pkg::ctrl_cmd_t  cmd_o
);

  lzd_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lzd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (status_i.kind)
            lzd_pkg::TK_LIT:  state_d = lzd_pkg::ST_EMIT;
            lzd_pkg::TK_COPY: state_d = lzd_pkg::ST_READ;
            default:          state_d = lzd_pkg::ST_IDLE;
          endcase
        end
      end
      lzd_pkg::ST_READ: begin
        cmd_o.issue_read = 1'b1;
        state_d          = lzd_pkg::ST_EMIT;
      end
      lzd_pkg::ST_EMIT: begin
        if (!status_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.final_byte ? lzd_pkg::ST_IDLE : lzd_pkg::ST_READ;
        end
      end
      default: state_d = lzd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/lzd_dp.sv
module lzd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  lzd_pkg::in_req_t    in_req_i,
  output lzd_pkg::out_req_t   out_req_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  lzd_pkg::ctrl_cmd_t  cmd_i,
  output lzd_pkg::dp_status_t status_o
);

  logic [lzd_pkg::ByteW-1:0] win_q [lzd_pkg::WinDepth];

  logic                      en_q, en_d;
  logic [lzd_pkg::WinAw-1:0] wp_q, wp_d;
  logic [lzd_pkg::FillW-1:0] fill_q, fill_d;
  logic [lzd_pkg::ByteW-1:0] flag_q, flag_d;
  logic [3:0]                left_q, left_d;
  lzd_pkg::phase_e           phase_q, phase_d;
  logic [lzd_pkg::ByteW-1:0] low_q, low_d;
  logic [lzd_pkg::ByteW-1:0] spos_q, spos_d;
  logic [lzd_pkg::WinAw-1:0] src_q, src_d;
  logic [lzd_pkg::RemW-1:0]  rem_q, rem_d;
  logic [lzd_pkg::ByteW-1:0] lit_q, lit_d;
  logic                      lit_mode_q, lit_mode_d;
  logic                      last_q, last_d;
  logic [lzd_pkg::ByteW-1:0] rdata_q;
  logic                      rvalid_q, rvalid_d;
  lzd_pkg::out_req_t         out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic [lzd_pkg::ByteW-1:0] b;
  logic [lzd_pkg::ByteW-1:0] emit_byte;
  logic [lzd_pkg::WinAw-1:0] rd_off;
  logic [3:0]                left_dec;
  logic                      final_byte;
  logic                      clr;
  lzd_pkg::tok_kind_e        kind;

  assign b          = in_req_i.in_byte ^ (en_q ? spos_q : '0);
  assign final_byte = lit_mode_q || (rem_q == '0);
  assign emit_byte  = lit_mode_q ? lit_q : (rvalid_q ? rdata_q : '0);
  assign rd_off     = src_q - lzd_pkg::WinStart;
  assign left_dec   = (left_q != '0) ? left_q - 4'd1 : left_q;

  always_comb begin
    priority if (phase_q == lzd_pkg::PH_TOKEN && flag_q[0]) begin
      kind = lzd_pkg::TK_LIT;
    end else if (phase_q == lzd_pkg::PH_HIGH) begin
      kind = lzd_pkg::TK_COPY;
    end else begin
      kind = lzd_pkg::TK_NONE;
    end
  end

  assign status_o.kind       = kind;
  assign status_o.final_byte = final_byte;
  assign status_o.out_full   = out_valid_q && out_stall_i;

  always_comb begin
    en_d        = en_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    flag_d      = flag_q;
    left_d      = left_q;
    phase_d     = phase_q;
    low_d       = low_q;
    spos_d      = spos_q;
    src_d       = src_q;
    rem_d       = rem_q;
    lit_d       = lit_q;
    lit_mode_d  = lit_mode_q;
    last_d      = last_q;
    rvalid_d    = rvalid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    clr         = 1'b0;

    if (cfg_we_i) begin
      en_d = cfg_wdata_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.accept) begin
      spos_d = spos_q + 8'd1;
      last_d = in_req_i.stream_end;
      unique case (phase_q)
        lzd_pkg::PH_TOKEN: begin
          if (flag_q[0]) begin
            lit_d      = b;
            lit_mode_d = 1'b1;
          end else begin
            low_d   = b;
            phase_d = lzd_pkg::PH_HIGH;
          end
        end
        lzd_pkg::PH_HIGH: begin
          src_d      = {b[7:4], low_q};
          rem_d      = {1'b0, b[3:0]} + lzd_pkg::RemW'(lzd_pkg::LenBias);
          lit_mode_d = 1'b0;
        end
        default: begin
          flag_d  = b;
          left_d  = lzd_pkg::FlagCount;
          phase_d = lzd_pkg::PH_TOKEN;
        end
      endcase
      if (in_req_i.stream_end && kind == lzd_pkg::TK_NONE) begin
        clr = 1'b1;
      end
    end

    if (cmd_i.issue_read) begin
      rvalid_d = {1'b0, rd_off} < fill_q;
    end

    if (cmd_i.emit) begin
      wp_d           = wp_q + 12'd1;
      fill_d         = fill_q + {{(lzd_pkg::FillW-1){1'b0}}, ~fill_q[lzd_pkg::FillW-1]};
      out_d.out_byte = emit_byte;
      out_d.run_last = final_byte;
      out_valid_d    = 1'b1;
      src_d          = src_q + 12'd1;
      rem_d          = rem_q - 5'd1;
      if (final_byte) begin
        flag_d  = flag_q >> 1;
        left_d  = left_dec;
        phase_d = (left_dec == '0) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_TOKEN;
        if (last_q) begin
          clr = 1'b1;
        end
      end
    end

    if (clr) begin
      wp_d    = lzd_pkg::WinStart;
      fill_d  = '0;
      flag_d  = '0;
      left_d  = '0;
      phase_d = lzd_pkg::PH_FLAG;
      low_d   = '0;
      spos_d  = '0;
    end
  end

  // window: written on emit, read on issue_read, never both in one cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      win_q[wp_q] <= emit_byte;
    end
    if (cmd_i.issue_read) begin
      rdata_q <= win_q[src_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b1;
      wp_q        <= lzd_pkg::WinStart;
      fill_q      <= '0;
      flag_q      <= '0;
      left_q      <= '0;
      phase_q     <= lzd_pkg::PH_FLAG;
      low_q       <= '0;
      spos_q      <= '0;
      lit_mode_q  <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      en_q        <= en_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      flag_q      <= flag_d;
      left_q      <= left_d;
      phase_q     <= phase_d;
      low_q       <= low_d;
      spos_q      <= spos_d;
      lit_mode_q  <= lit_mode_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    rem_q    <= rem_d;
    lit_q    <= lit_d;
    rvalid_q <= rvalid_d;
    out_q    <= out_d;
  end

  assign out_req_o   = out_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/xor_descramble_lzss_decoder.sv
// channel  | direction | handshake                | payload
// in       | request   | in_valid_i / in_stall_o  | in_req_i  (in_byte, stream_end)
// out      | result    | out_valid_o / out_stall_i| out_req_o (out_byte, run_last)
// cfg      | write     | cfg_we_i                 | cfg_wdata_i (descramble enable)
// flag bytes, match low bytes and dropped tokens are taken in the idle state alone
// a literal goes idle then emit, a match idle then read and emit per byte (3 to 18 bytes)
// each copied byte needs a window read step then a window write step
// reset is asynchronous; the window is not cleared, a fill count marks written entries
// out_stall_i holds the block in its emit step; a request is taken while a result waits
module xor_descramble_lzss_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lzd_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzd_pkg::out_req_t  out_req_o
);

  lzd_pkg::ctrl_cmd_t  cmd;
  lzd_pkg::dp_status_t status;

  lzd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lzd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .out_req_o   (out_req_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("emit while result register full");

  a_emit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("emitted byte not presented");

  a_final_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.final_byte) |=> !in_stall_o)
    else $error("not ready after last byte of a token");

  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue_read |=> (!cmd.issue_read && !cmd.accept))
    else $error("window read not followed by emit step");
`endif

endmodule

FILE: bench/xor_descramble_lzss_decoder_tb.sv
module xor_descramble_lzss_decoder_tb;
  import lzd_pkg::*;

  class lzss_scoreboard;
    logic [ByteW-1:0] window [WinDepth];
    logic [WinAw-1:0] wr_ptr;
    logic [7:0]       flag_bits;
    logic [3:0]       flags_left;
    phase_e           phase;
    logic [7:0]       copy_low;
    logic [7:0]       position;
    logic             enable;
    out_req_t         decoded_due [$];
    int               errors;
    int               n_decoded;
    int               n_literals;
    int               n_copies;

    function void clear_stream();
      foreach (window[i]) window[i] = '0;
      wr_ptr     = WinStart;
      flag_bits  = '0;
      flags_left = '0;
      phase      = PH_FLAG;
      copy_low   = '0;
      position   = '0;
    endfunction

    function void put_byte(logic [7:0] b);
      out_req_t e;
      window[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      e.out_byte = b;
      e.run_last = 1'b0;
      decoded_due.push_back(e);
    endfunction

    function void token_done();
      flag_bits = flag_bits >> 1;
      if (flags_left != 0) flags_left = flags_left - 1'b1;
      phase = (flags_left == 0) ? PH_FLAG : PH_TOKEN;
    endfunction

    function void take_packed(in_req_t r);
      logic [7:0]       b;
      logic [WinAw-1:0] src;
      int               len;
      int               first;
      b = enable ? (r.in_byte ^ position) : r.in_byte;
      position = position + 8'd1;
      first = decoded_due.size();
      case (phase)
        PH_TOKEN: begin
          if (flag_bits[0]) begin
            put_byte(b);
            n_literals++;
            token_done();
          end else begin
            copy_low = b;
            phase = PH_HIGH;
          end
        end
        PH_HIGH: begin
          src = {b[7:4], copy_low};
          len = int'(b[3:0]) + LenBias + 1;
          for (int k = 0; k < len; k++) put_byte(window[WinAw'(src + k)]);
          n_copies++;
          token_done();
        end
        default: begin
          flag_bits  = b;
          flags_left = FlagCount;
          phase      = PH_TOKEN;
        end
      endcase
      if (decoded_due.size() > first) decoded_due[$].run_last = 1'b1;
      if (r.stream_end) clear_stream();
    endfunction

    function void match_decoded(out_req_t got);
      out_req_t want;
      if (decoded_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %02h last %0b",
                 $time, got.out_byte, got.run_last);
        errors++;
        return;
      end
      want = decoded_due.pop_front();
      n_decoded++;
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last expected %0b got %0b", $time, want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_req_t out_req_o;

  lzss_scoreboard sb;
  logic       cur_enable;
  logic [7:0] tx_pos;
  bit         calm;
  bit         long_hold;
  int         stall_left;
  int         gap_pct;
  int         stall_pct;
  int         n_requests;
  int         n_streams;
  int         n_holds;
  int         n_wraps;

  xor_descramble_lzss_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.match_decoded(out_req_o);
  end

  // receiver side stalls, long hold counted here
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold  = 1'b0;
        stall_left = 300;
        n_holds++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        stall_left = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_plain(input logic [7:0] plain, input logic last);
    in_req_t r;
    int      n;
    if (!calm && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(negedge clk_i);
    end
    r.in_byte    = cur_enable ? (plain ^ tx_pos) : plain;
    r.stream_end = last;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_packed(r);
    n_requests++;
    tx_pos = last ? 8'd0 : tx_pos + 8'd1;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.decoded_due.size() != 0) @(posedge clk_i);
    repeat (48) @(negedge clk_i);
  endtask

  task automatic write_enable(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_enable = v;
    sb.enable  = v;
  endtask

  task automatic send_stream(input logic [7:0] q [$], input int hold_at, input int pause_at);
    for (int i = 0; i < q.size(); i++) begin
      if (i == hold_at) long_hold = 1'b1;
      if (i == pause_at) drain();
      send_plain(q[i], i == q.size() - 1);
    end
    n_streams++;
    if (q.size() > 256) n_wraps++;
  endtask

  // well-formed flag/token groups or noise bytes, cut at n; a tail token may be cut
  task automatic build_stream(input int n, input bit noise, input int hold_at,
                              input int pause_at);
    logic [7:0]       q [$];
    logic [7:0]       f;
    logic [WinAw-1:0] wr;
    logic [WinAw-1:0] src;
    int               len;
    wr = WinStart;
    while (q.size() < n) begin
      if (noise) begin
        q.push_back(8'($urandom));
      end else begin
        f = 8'($urandom);
        q.push_back(f);
        for (int i = 0; i < 8; i++) begin
          if (f[i]) begin
            q.push_back(8'($urandom));
            wr = wr + 1'b1;
          end else begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            src = ($urandom_range(0, 3) == 0) ? WinAw'($urandom)
                                              : wr - WinAw'($urandom_range(1, 40));
            q.push_back(src[7:0]);
            q.push_back({src[11:8], 4'(len)});
            wr = wr + WinAw'(len + LenBias + 1);
          end
        end
      end
    end
    while (q.size() > n) void'(q.pop_back());
    send_stream(q, hold_at, pause_at);
  endtask

  initial begin
    int random_sent;
    int len;
    int k;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    sb = new();
    sb.clear_stream();
    sb.enable  = 1'b1;
    cur_enable = 1'b1;
    tx_pos     = '0;
    gap_pct    = 20;
    stall_pct  = 20;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // literal extremes, overlapping copy, copy from cleared window with pointer wrap,
    // longest copy at top of window, truncated copy at stream end
    send_stream('{8'hF5, 8'hFF, 8'hEE, 8'hF0, 8'h00, 8'h00, 8'h0F, 8'h5A, 8'hA5, 8'h7F,
                  8'h80, 8'h00, 8'hFF, 8'hFF, 8'h12}, -1, -1);
    drain();
    write_enable(1'b0);
    // flag byte that ends the stream, then a short raw stream
    send_stream('{8'hFF}, -1, -1);
    send_stream('{8'h01, 8'hFF, 8'hEE, 8'hF2}, -1, -1);

    random_sent = 0;
    k = 0;
    while (random_sent < 300) begin
      drain();
      write_enable((k < 2) ? k[0] : 1'($urandom));
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      calm = (random_sent > 250);
      len = (k == 0) ? 258 : $urandom_range(6, 40);
      build_stream(len, (k > 1) && ($urandom_range(0, 5) == 0),
                   (k == 0) ? 20 : -1, (k == 2) ? len / 2 : -1);
      random_sent += len;
      k++;
    end

    drain();
    $display("%0d requests in %0d streams, %0d bytes decoded (%0d literals, %0d copies)",
             n_requests, n_streams, sb.n_decoded, sb.n_literals, sb.n_copies);
    $display("both descramble settings, %0d long output holds, %0d position wraps",
             n_holds, n_wraps);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lzd_pkg.sv
rtl/lzd_ctrl.sv
rtl/lzd_dp.sv
rtl/xor_descramble_lzss_decoder.sv
bench/xor_descramble_lzss_decoder_tb.sv
